FILE: src/sswin_pkg.sv
package sswin_pkg;

	// item kinds
	localparam logic [2:0] KIND_BUFFER     = 3'd0;
	localparam logic [2:0] KIND_ACK        = 3'd1;
	localparam logic [2:0] KIND_FETCH      = 3'd2;
	localparam logic [2:0] KIND_FETCH_BASE = 3'd3;
	localparam logic [2:0] KIND_MARK_SENT  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_WINDOW = 1'd1;

	// configuration reset values
	localparam logic [5:0]  SLOT_COUNT_RST = 6'd32;
	localparam logic [15:0] MAX_WINDOW_RST = 16'd0;

	// state reset values
	localparam logic [31:0] SEQ_RST       = 32'd1;
	localparam logic [31:0] LAST_SENT_RST = 32'd0;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] seq_or_ack;
		logic [15:0] data_length;
		logic [15:0] payload_handle;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] entry_seq;
		logic [15:0] entry_length;
		logic [15:0] entry_handle;
		logic [15:0] entry_window;
		logic        more_unacked;
		logic [31:0] send_base_out;
		logic [31:0] next_seq_out;
		logic [31:0] last_sent_out;
	} out_item_t;

	// one segment descriptor as stored in the ring
	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] length;
		logic [15:0] handle;
	} entry_t;

endpackage

FILE: src/sswin_mem.sv
module sswin_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  sswin_pkg::entry_t wr_data,
	input  logic [AW-1:0]     rd_addr,
	output sswin_pkg::entry_t rd_data
);
	import sswin_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// descriptor store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/sswin_ctrl.sv
module sswin_ctrl #(
	parameter int unsigned IW    = 5,
	parameter int unsigned CW    = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sswin_pkg::in_item_t  item,
	output logic                 done,
	output sswin_pkg::out_item_t result,
	input  logic [CW-1:0]        eff_n,
	input  logic [15:0]          max_window,
	output logic                 mem_wr_en,
	output logic [IW-1:0]        mem_wr_addr,
	output sswin_pkg::entry_t    mem_wr_data,
	output logic [IW-1:0]        mem_rd_addr,
	input  sswin_pkg::entry_t    mem_rd_data
);
	import sswin_pkg::*;

	localparam int unsigned BW = (IW > 1) ? $clog2(IW) : 1;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_REDUCE   = 3'd1;
	localparam logic [2:0] S_DISPATCH = 3'd2;
	localparam logic [2:0] S_SCAN     = 3'd3;
	localparam logic [2:0] S_RESP     = 3'd4;

	logic [2:0]    state_q;
	in_item_t      item_q;
	logic [BW-1:0] bit_q;
	logic [CW-1:0] rem_q;
	logic [IW-1:0] p_q;
	logic [CW-1:0] left_q;
	logic [1:0]    st_q;
	entry_t        ent_q;
	logic          hit_q;
	logic          more_q;
	out_item_t     res_q;
	logic          done_q;

	logic [IW-1:0] base_q;
	logic [CW-1:0] occ_q;
	logic [31:0]   send_base_q;
	logic [31:0]   next_seq_q;
	logic [31:0]   last_sent_q;

	logic [CW:0]   rem_sh;
	logic [CW:0]   rem_nx;
	logic [CW-1:0] p_inc;
	logic [IW-1:0] p_next;
	logic [CW:0]   pos_sum;
	logic [CW:0]   pos_mod;
	logic          full;

	// base slot reduced modulo the slot count, one bit per cycle
	always_comb begin
		rem_sh = {rem_q, base_q[bit_q]};
		if (rem_sh >= (CW+1)'(eff_n)) begin
			rem_nx = rem_sh - (CW+1)'(eff_n);
		end else begin
			rem_nx = rem_sh;
		end
	end

	// ring position step with wrap at the slot count
	assign p_inc  = CW'(p_q) + CW'(1);
	assign p_next = (p_inc == eff_n) ? '0 : p_inc[IW-1:0];

	// tail position for a new descriptor
	always_comb begin
		pos_sum = (CW+1)'(p_q) + (CW+1)'(occ_q);
		if (pos_sum >= (CW+1)'(eff_n)) begin
			pos_mod = pos_sum - (CW+1)'(eff_n);
		end else begin
			pos_mod = pos_sum;
		end
	end

	assign full = (occ_q >= eff_n);

	// memory access
	assign mem_wr_en   = (state_q == S_DISPATCH) && (item_q.kind == KIND_BUFFER) && !full;
	assign mem_wr_addr = pos_mod[IW-1:0];
	assign mem_wr_data = '{seq: next_seq_q, length: item_q.data_length,
		handle: item_q.payload_handle};
	assign mem_rd_addr = (state_q == S_SCAN) ? p_next : p_q;

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			base_q      <= '0;
			occ_q       <= '0;
			send_base_q <= SEQ_RST;
			next_seq_q  <= SEQ_RST;
			last_sent_q <= LAST_SENT_RST;
		end else begin
			done_q <= (state_q == S_RESP);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (bit_q == '0) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (item_q.kind)
						KIND_BUFFER: begin
							state_q <= S_RESP;
							if (!full) begin
								occ_q      <= occ_q + CW'(1);
								next_seq_q <= next_seq_q + 32'(item_q.data_length);
							end
						end
						KIND_ACK: begin
							send_base_q <= item_q.seq_or_ack;
							if (occ_q == '0) begin
								base_q  <= p_q;
								state_q <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end
						KIND_FETCH, KIND_FETCH_BASE: begin
							if (occ_q != '0) begin
								state_q <= S_SCAN;
							end else begin
								state_q <= S_RESP;
							end
						end
						KIND_MARK_SENT: begin
							state_q     <= S_RESP;
							last_sent_q <= item_q.seq_or_ack + 32'(item_q.data_length)
								- 32'd1;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_SCAN: begin
					case (item_q.kind)
						KIND_ACK: begin
							if (mem_rd_data.seq >= item_q.seq_or_ack) begin
								base_q  <= p_q;
								state_q <= S_RESP;
							end else begin
								occ_q  <= occ_q - CW'(1);
								base_q <= p_next;
								if (occ_q == CW'(1)) begin
									state_q <= S_RESP;
								end
							end
						end
						KIND_FETCH: begin
							if (mem_rd_data.seq == item_q.seq_or_ack || left_q == CW'(1)) begin
								state_q <= S_RESP;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-transaction working registers and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= item;
				bit_q  <= BW'(IW - 1);
				rem_q  <= '0;
				st_q   <= ST_OK;
				ent_q  <= '0;
				hit_q  <= 1'b0;
				more_q <= 1'b0;
			end
			S_REDUCE: begin
				rem_q <= rem_nx[CW-1:0];
				bit_q <= bit_q - BW'(1);
				if (bit_q == '0) begin
					p_q <= rem_nx[IW-1:0];
				end
			end
			S_DISPATCH: begin
				left_q <= occ_q;
				case (item_q.kind)
					KIND_BUFFER: begin
						if (full) begin
							st_q <= ST_FULL;
						end else begin
							ent_q <= mem_wr_data;
							hit_q <= 1'b1;
						end
					end
					KIND_FETCH, KIND_FETCH_BASE: begin
						if (occ_q == '0) begin
							st_q <= ST_NOT_FOUND;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				case (item_q.kind)
					KIND_ACK: begin
						if (mem_rd_data.seq >= item_q.seq_or_ack) begin
							more_q <= 1'b1;
						end else begin
							p_q <= p_next;
						end
					end
					KIND_FETCH: begin
						if (mem_rd_data.seq == item_q.seq_or_ack) begin
							ent_q <= mem_rd_data;
							hit_q <= 1'b1;
						end else if (left_q == CW'(1)) begin
							st_q <= ST_NOT_FOUND;
						end else begin
							left_q <= left_q - CW'(1);
							p_q    <= p_next;
						end
					end
					KIND_FETCH_BASE: begin
						ent_q <= mem_rd_data;
						hit_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_RESP: begin
				res_q.status        <= st_q;
				res_q.entry_seq     <= ent_q.seq;
				res_q.entry_length  <= ent_q.length;
				res_q.entry_handle  <= ent_q.handle;
				res_q.entry_window  <= hit_q ? max_window : 16'd0;
				res_q.more_unacked  <= more_q;
				res_q.send_base_out <= send_base_q;
				res_q.next_seq_out  <= next_seq_q;
				res_q.last_sent_out <= last_sent_q;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: src/sender_sliding_window_core.sv
// Sender sliding window: ring of unacknowledged segment descriptors.
// Command channel: present item while busy is low and raise start; the
// transaction is taken at that edge and busy rises the next cycle.
// Kinds: buffer a segment, ack, fetch by sequence number, fetch base,
// mark sent. Every transaction yields exactly one result on result,
// marked by a one-cycle done strobe; the receiver cannot stall it.
// A transaction passes through base slot reduction modulo the slot count
// (one bit per cycle), dispatch, a scan over at most the occupied entries
// for ack and fetch (one memory read per cycle) and the result register.
// busy drops in the cycle done is high, so the next start may follow then.
// Configuration: cfg_we with cfg_index 0 (slot_count) or 1 (max window
// bytes); write only while busy is low.
// Reset clears the ring to empty, send base and next sequence to 1, last
// sent to 0, slot_count to 32; descriptor memory contents are not cleared.
module sender_sliding_window_core #(
	parameter int unsigned SLOTS = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  sswin_pkg::in_item_t                     item,
	output logic                                    done,
	output sswin_pkg::out_item_t                    result,
	input  logic                                    cfg_we,
	input  logic [sswin_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [sswin_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import sswin_pkg::*;

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned XW = (CW > 6) ? CW : 6;

	logic [5:0]    slot_count_q;
	logic [15:0]   max_window_q;
	logic [XW-1:0] sc_ext;
	logic [CW-1:0] eff_n;

	logic          mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	entry_t        mem_wr_data;
	logic [IW-1:0] mem_rd_addr;
	entry_t        mem_rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
			max_window_q <= MAX_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_COUNT: slot_count_q <= cfg_data[5:0];
				REG_MAX_WINDOW: max_window_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// effective slot count, saturated to 1..SLOTS
	always_comb begin
		sc_ext = XW'(slot_count_q);
		if (sc_ext == '0) begin
			eff_n = CW'(1);
		end else if (sc_ext > XW'(SLOTS)) begin
			eff_n = CW'(SLOTS);
		end else begin
			eff_n = sc_ext[CW-1:0];
		end
	end

	sswin_ctrl #(
		.IW    (IW),
		.CW    (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.eff_n       (eff_n),
		.max_window  (max_window_q),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	sswin_mem #(
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule
